// ----- src/ipr_pkg.sv -----
// Shared types, constants and the helper function of the pixel-to-RGB converter.
`default_nettype none

package ipr_pkg;

   // Largest frame side the counters are sized for
   localparam int DEFAULT_MAX_DIM = 1024;

   // Register file geometry
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int FMT_W      = 2;
   localparam int DIM_CFG_W  = 11;

   localparam logic [FMT_W-1:0]     RST_FORMAT = 2'd0;
   localparam logic [DIM_CFG_W-1:0] RST_WIDTH  = 11'd720;
   localparam logic [DIM_CFG_W-1:0] RST_HEIGHT = 11'd480;

   // Output field widths
   localparam int CHAN_W = 16;
   localparam int POS_W  = 10;

   // Q16 luma is 0..65536, chroma offsets are signed 18 bits
   localparam int LUMA_W = 17;
   localparam int CHROMA_W = 18;
   localparam int COEF_W = 19;
   localparam int PROD_W = COEF_W + CHROMA_W;
   localparam int SUM_W  = 38;

   // Color matrix coefficients, Q16
   localparam logic signed [COEF_W-1:0] K_RV = 19'sd74711;
   localparam logic signed [COEF_W-1:0] K_GU = 19'sd25821;
   localparam logic signed [COEF_W-1:0] K_GV = 19'sd38076;
   localparam logic signed [COEF_W-1:0] K_BU = 19'sd132907;

   localparam logic signed [CHROMA_W-1:0] CHROMA_MID = 18'sd32768;

   typedef enum logic [FMT_W-1:0] {
      FMT_UYVY   = 2'd0,
      FMT_NIBBLE = 2'd1,
      FMT_RGB555 = 2'd2
   } pix_fmt_type;

   typedef enum logic [1:0] {
      REG_FORMAT = 2'd0,
      REG_WIDTH  = 2'd1,
      REG_HEIGHT = 2'd2
   } reg_index_type;

   // Coordinates of one input word
   typedef struct packed {
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] column;
      logic             eof;
   } word_pos_type;

   // Coordinates of one output pixel
   typedef struct packed {
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] column;
      logic             last;
      logic             eof;
   } pix_pos_type;

   // One pixel after the multiply stage
   typedef struct packed {
      logic                      is_rgb;
      logic [CHAN_W-1:0]         red;
      logic [CHAN_W-1:0]         green;
      logic [CHAN_W-1:0]         blue;
      logic [LUMA_W-1:0]         luma;
      logic signed [PROD_W-1:0]  prod_rv;
      logic signed [PROD_W-1:0]  prod_gu;
      logic signed [PROD_W-1:0]  prod_gv;
      logic signed [PROD_W-1:0]  prod_bu;
      pix_pos_type               pos;
   } pix_prod_type;

   // round(b * 65536 / 255) = b * 257 + (b >= 128)
   function automatic logic [LUMA_W-1:0] byte_q16(input logic [7:0] b);
      byte_q16 = LUMA_W'({b, b}) + LUMA_W'(b[7]);
   endfunction

endpackage

`default_nettype wire

// ----- src/ipr_frame_counter.sv -----
// Column, row and field counters that place each input word in the frame.
`default_nettype none

module ipr_frame_counter #(
   parameter int MAX_DIM = ipr_pkg::DEFAULT_MAX_DIM
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           advance,
   input  wire logic [ipr_pkg::FMT_W-1:0]      fmt,
   input  wire logic [ipr_pkg::DIM_CFG_W-1:0]  cfg_width,
   input  wire logic [ipr_pkg::DIM_CFG_W-1:0]  cfg_height,
   output ipr_pkg::word_pos_type               pos
);
   import ipr_pkg::*;

   localparam int CNT_W   = $clog2(MAX_DIM);
   localparam int SUM_CW  = CNT_W + 1;
   localparam int DIM_W   = (SUM_CW > DIM_CFG_W) ? SUM_CW : DIM_CFG_W;
   localparam int MAX_EVEN = MAX_DIM - (MAX_DIM % 2);
   localparam int WIDE_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

   logic [CNT_W-1:0]  col_ff, col_in;
   logic [CNT_W-1:0]  line_ff, line_in;
   logic              field_ff, field_in;

   logic [SUM_CW-1:0] width_eff, height_eff;
   logic [SUM_CW-1:0] col_sum, line_sum, line_step;
   logic [WIDE_W-1:0] col_wide, line_wide;
   logic              fmt_uyvy, col_wrap, line_over, word_eof;

   // Even size clamped to 2..MAX_DIM
   function automatic logic [SUM_CW-1:0] eff_dim(input logic [DIM_CFG_W-1:0] v);
      logic [DIM_W-1:0] e;
      e = DIM_W'(v) & ~DIM_W'(1);
      if (e < DIM_W'(2))
         e = DIM_W'(2);
      if (e > DIM_W'(MAX_DIM))
         e = DIM_W'(MAX_EVEN);
      eff_dim = e[SUM_CW-1:0];
   endfunction

   assign width_eff  = eff_dim(cfg_width);
   assign height_eff = eff_dim(cfg_height);

   // Wrap decisions for the word being accepted
   assign fmt_uyvy  = (fmt == FMT_UYVY);
   assign col_sum   = {1'b0, col_ff} + SUM_CW'(2);
   assign col_wrap  = (col_sum >= width_eff);
   assign line_step = fmt_uyvy ? SUM_CW'(2) : SUM_CW'(1);
   assign line_sum  = {1'b0, line_ff} + line_step;
   assign line_over = (line_sum >= height_eff);
   assign word_eof  = col_wrap && line_over && (!fmt_uyvy || field_ff);

   assign col_wide   = WIDE_W'(col_ff);
   assign line_wide  = WIDE_W'(line_ff);
   assign pos.row    = line_wide[POS_W-1:0];
   assign pos.column = col_wide[POS_W-1:0];
   assign pos.eof    = word_eof;

   // Next counter values
   always_comb begin
      col_in   = col_ff;
      line_in  = line_ff;
      field_in = field_ff;
      if (advance) begin
         if (!col_wrap) begin
            col_in = col_sum[CNT_W-1:0];
         end else begin
            col_in = '0;
            if (!line_over) begin
               line_in = line_sum[CNT_W-1:0];
            end else if (fmt_uyvy && !field_ff) begin
               line_in  = CNT_W'(1);
               field_in = 1'b1;
            end else begin
               line_in  = '0;
               field_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         line_ff  <= '0;
         field_ff <= 1'b0;
      end else begin
         col_ff   <= col_in;
         line_ff  <= line_in;
         field_ff <= field_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/ipr_pixel_mult.sv -----
// Pixel decode and chroma multiply stage: one pixel of the held word per cycle while load is high.
`default_nettype none

module ipr_pixel_mult (
   input  wire logic                        clock,
   input  wire logic                        load,
   input  wire logic [31:0]                 word,
   input  wire logic [ipr_pkg::FMT_W-1:0]   fmt,
   input  wire logic                        half,
   input  wire ipr_pkg::pix_pos_type        pos,
   output ipr_pkg::pix_prod_type            prod
);
   import ipr_pkg::*;

   logic [7:0]                 hi, lo;
   logic signed [CHROMA_W-1:0] du, dv;
   logic                       is_rgb;
   pix_prod_type               prod_in, prod_ff;

   // Byte pair of the selected pixel
   assign hi = half ? word[15:8] : word[31:24];
   assign lo = half ? word[7:0]  : word[23:16];

   // Chroma offsets per format
   always_comb begin
      du     = '0;
      dv     = '0;
      is_rgb = 1'b0;
      case (fmt)
         FMT_UYVY: begin
            du = $signed({1'b0, byte_q16(word[31:24])}) - CHROMA_MID;
            dv = $signed({1'b0, byte_q16(word[15:8])}) - CHROMA_MID;
         end
         FMT_NIBBLE: begin
            // nibble * 4096 - 32768 is the nibble with its top bit flipped
            du = $signed({{2{~hi[7]}}, ~hi[7], hi[6:4], 12'b0});
            dv = $signed({{2{~hi[3]}}, ~hi[3], hi[2:0], 12'b0});
         end
         default: begin
            is_rgb = 1'b1;
         end
      endcase
   end

   always_comb begin
      prod_in.is_rgb  = is_rgb;
      prod_in.red     = {3'b0, hi[6:2], 8'b0};
      prod_in.green   = {3'b0, hi[1:0], lo[7:5], 8'b0};
      prod_in.blue    = {3'b0, lo[4:0], 8'b0};
      prod_in.luma    = byte_q16(lo);
      prod_in.prod_rv = K_RV * dv;
      prod_in.prod_gu = K_GU * du;
      prod_in.prod_gv = K_GV * dv;
      prod_in.prod_bu = K_BU * du;
      prod_in.pos     = pos;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

// ----- src/ipr_pixel_finish.sv -----
// Channel sums, clamp and scale to 16 bits (RGB555 bypasses these), and the result register.
`default_nettype none

module ipr_pixel_finish (
   input  wire logic                           clock,
   input  wire logic                           load,
   input  wire ipr_pkg::pix_prod_type          prod,
   output logic [ipr_pkg::CHAN_W-1:0]          red,
   output logic [ipr_pkg::CHAN_W-1:0]          green,
   output logic [ipr_pkg::CHAN_W-1:0]          blue,
   output logic [ipr_pkg::POS_W-1:0]           row,
   output logic [ipr_pkg::POS_W-1:0]           column,
   output logic                                last_of_pair,
   output logic                                end_of_frame
);
   import ipr_pkg::*;

   logic signed [SUM_W-1:0] base, sum_r, sum_g, sum_b;
   logic [CHAN_W-1:0]       red_in, green_in, blue_in;
   logic [CHAN_W-1:0]       red_ff, green_ff, blue_ff;
   pix_pos_type             pos_ff;

   function automatic logic signed [SUM_W-1:0] ext(input logic signed [PROD_W-1:0] p);
      ext = {{(SUM_W - PROD_W){p[PROD_W-1]}}, p};
   endfunction

   // Q32 sum to 16 bits: <= 0 gives 0, >= 1.0 gives full scale, else s*65535 >> 32
   function automatic logic [CHAN_W-1:0] chan(input logic signed [SUM_W-1:0] s);
      logic [47:0] scaled;
      scaled = {s[31:0], 16'b0} - {16'b0, s[31:0]};
      if (s[SUM_W-1] || (s == '0))
         chan = '0;
      else if (s[SUM_W-2:32] != '0)
         chan = '1;
      else
         chan = scaled[47:32];
   endfunction

   assign base  = $signed({5'b0, prod.luma, 16'b0});
   assign sum_r = base + ext(prod.prod_rv);
   assign sum_g = base - ext(prod.prod_gu) - ext(prod.prod_gv);
   assign sum_b = base + ext(prod.prod_bu);

   // RGB555 pixels bypass the matrix
   always_comb begin
      if (prod.is_rgb) begin
         red_in   = prod.red;
         green_in = prod.green;
         blue_in  = prod.blue;
      end else begin
         red_in   = chan(sum_r);
         green_in = chan(sum_g);
         blue_in  = chan(sum_b);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
         pos_ff   <= prod.pos;
      end
   end

   assign red          = red_ff;
   assign green        = green_ff;
   assign blue         = blue_ff;
   assign row          = pos_ff.row;
   assign column       = pos_ff.column;
   assign last_of_pair = pos_ff.last;
   assign end_of_frame = pos_ff.eof;

endmodule

`default_nettype wire

// ----- src/ithmb_pixel_to_rgb.sv -----
// Top level of the pixel-word to RGB converter with frame coordinates.
//
// Each accepted 32-bit word (first file byte in bits 31..24) yields two RGB
// pixels, delivered one per cycle unless stalled, as the single pixel
// conversion path handles one pixel per clock; a new word is taken only as
// the held word's second pixel moves on. A word's first pixel passes the
// input, multiply and result registers. The input register takes the next
// word in the cycle its second pixel enters the multiply stage, even while
// the result register waits on rsp_stall. Frame position (row, column,
// field) is assigned when a word is accepted; format 0 fills even rows in
// the first field and odd rows in the second. Registers: pixel_format at
// 0x0, frame_width at 0x4, frame_height at 0x8; write them only while idle.
`default_nettype none

module ithmb_pixel_to_rgb #(
   parameter int MAX_DIM = ipr_pkg::DEFAULT_MAX_DIM
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // input words
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [31:0]                     req_pixel_word,
   // result pixels
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [ipr_pkg::CHAN_W-1:0]           rsp_red,
   output logic [ipr_pkg::CHAN_W-1:0]           rsp_green,
   output logic [ipr_pkg::CHAN_W-1:0]           rsp_blue,
   output logic [ipr_pkg::POS_W-1:0]            rsp_row,
   output logic [ipr_pkg::POS_W-1:0]            rsp_column,
   output logic                                 rsp_last_of_pair,
   output logic                                 rsp_end_of_frame,
   // register port
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [ipr_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [ipr_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [ipr_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                 pready
);
   import ipr_pkg::*;

   // Configuration registers
   logic [FMT_W-1:0]     fmt_ff;
   logic [DIM_CFG_W-1:0] width_ff, height_ff;
   logic                 csr_write;

   // Input word stage
   logic                 s0_valid_ff, s0_valid_in;
   logic                 s0_half_ff, s0_half_in;
   logic [31:0]          s0_word_ff;
   logic [FMT_W-1:0]     s0_fmt_ff;
   word_pos_type         s0_pos_ff;

   // Downstream stage valids
   logic                 s1_valid_ff, s1_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                 accept, s1_load, s2_load;
   word_pos_type         word_pos;
   pix_pos_type          pix_pos;
   pix_prod_type         prod;

   // Register writes and reads
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff    <= RST_FORMAT;
         width_ff  <= RST_WIDTH;
         height_ff <= RST_HEIGHT;
      end else if (csr_write) begin
         case (paddr[3:2])
            REG_FORMAT: fmt_ff    <= pwdata[FMT_W-1:0];
            REG_WIDTH:  width_ff  <= pwdata[DIM_CFG_W-1:0];
            REG_HEIGHT: height_ff <= pwdata[DIM_CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_FORMAT: prdata = CSR_DATA_W'(fmt_ff);
         REG_WIDTH:  prdata = CSR_DATA_W'(width_ff);
         REG_HEIGHT: prdata = CSR_DATA_W'(height_ff);
         default:    prdata = '0;
      endcase
   end

   // Pipeline handshake
   assign s2_load   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign s1_load   = s0_valid_ff && (!s1_valid_ff || s2_load);
   assign req_stall = s0_valid_ff && !(s1_load && s0_half_ff);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      s0_valid_in = s0_valid_ff;
      s0_half_in  = s0_half_ff;
      if (accept) begin
         s0_valid_in = 1'b1;
         s0_half_in  = 1'b0;
      end else if (s1_load) begin
         s0_valid_in = !s0_half_ff;
         s0_half_in  = 1'b1;
      end
      s1_valid_in  = s1_load ? 1'b1 : (s2_load ? 1'b0 : s1_valid_ff);
      rsp_valid_in = s2_load ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s0_half_ff   <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         s0_half_ff   <= s0_half_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Word payload, format and position captured per transaction
   always_ff @(posedge clock) begin
      if (accept) begin
         s0_word_ff <= req_pixel_word;
         s0_fmt_ff  <= fmt_ff;
         s0_pos_ff  <= word_pos;
      end
   end

   ipr_frame_counter #(
      .MAX_DIM (MAX_DIM)
   ) u_counter (
      .clock      (clock),
      .reset      (reset),
      .advance    (accept),
      .fmt        (fmt_ff),
      .cfg_width  (width_ff),
      .cfg_height (height_ff),
      .pos        (word_pos)
   );

   // Position of the pixel leaving the word stage
   always_comb begin
      pix_pos.row    = s0_pos_ff.row;
      pix_pos.column = s0_half_ff ? (s0_pos_ff.column + POS_W'(1)) : s0_pos_ff.column;
      pix_pos.last   = s0_half_ff;
      pix_pos.eof    = s0_half_ff && s0_pos_ff.eof;
   end

   ipr_pixel_mult u_mult (
      .clock (clock),
      .load  (s1_load),
      .word  (s0_word_ff),
      .fmt   (s0_fmt_ff),
      .half  (s0_half_ff),
      .pos   (pix_pos),
      .prod  (prod)
   );

   ipr_pixel_finish u_finish (
      .clock        (clock),
      .load         (s2_load),
      .prod         (prod),
      .red          (rsp_red),
      .green        (rsp_green),
      .blue         (rsp_blue),
      .row          (rsp_row),
      .column       (rsp_column),
      .last_of_pair (rsp_last_of_pair),
      .end_of_frame (rsp_end_of_frame)
   );

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire
